// File: rtl/cpt_pkg.sv
// Shared constants and types for the closest-point-on-triangle pipeline.
// No dependencies.
package cpt_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  // operand slice width of the split multipliers
  localparam int MUL_CHUNK = 24;

  typedef enum logic [2:0] {
    RGN_A    = 3'd0,
    RGN_B    = 3'd1,
    RGN_C    = 3'd2,
    RGN_AB   = 3'd3,
    RGN_BC   = 3'd4,
    RGN_CA   = 3'd5,
    RGN_FACE = 3'd6
  } region_t;

endpackage

// File: rtl/cpt_mul.sv
// Two-stage signed multiplier built from MUL_CHUNK x MUL_CHUNK partial products.
// Depends on cpt_pkg.
module cpt_mul #(
  parameter int AW = 25,
  parameter int BW = 25
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [AW-1:0]  a_i,
  input  logic signed [BW-1:0]  b_i,
  output logic signed [AW+BW-1:0] p_o
);
  import cpt_pkg::*;

  localparam int NA  = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AXW = NA * MUL_CHUNK;
  localparam int BXW = NB * MUL_CHUNK;
  localparam int PW  = AW + BW;

  logic [AXW-1:0]           amag;
  logic [BXW-1:0]           bmag;
  logic [2*MUL_CHUNK-1:0]   pp_nxt [NA*NB];
  logic [2*MUL_CHUNK-1:0]   pp_r   [NA*NB];
  logic                     neg_r;
  logic [PW-1:0]            acc;
  logic signed [PW-1:0]     p_nxt;
  logic signed [PW-1:0]     p_r;

  // magnitudes, sliced products
  always_comb begin
    amag = a_i[AW-1] ? AXW'(-(AW+1)'(a_i)) : AXW'(a_i);
    bmag = b_i[BW-1] ? BXW'(-(BW+1)'(b_i)) : BXW'(b_i);
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i*NB+j] = amag[i*MUL_CHUNK +: MUL_CHUNK] * bmag[j*MUL_CHUNK +: MUL_CHUNK];
      end
    end
  end

  // weighted sum of partials, then sign
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp_r[i*NB+j]) << (MUL_CHUNK * (i + j)));
      end
    end
    p_nxt = neg_r ? -$signed(acc) : $signed(acc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r  <= pp_nxt;
      neg_r <= a_i[AW-1] ^ b_i[BW-1];
      p_r   <= p_nxt;
    end
  end

  assign p_o = p_r;

endmodule

// File: rtl/cpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
// Standalone; quotient magnitude must fit QB bits.
module cpt_div #(
  parameter int NW = 131,
  parameter int DW = 106,
  parameter int QB = 25
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output logic signed [QB:0]   quo_o
);

  localparam int XW = (NW > DW + QB) ? NW : DW + QB;

  logic [XW-1:0]    rem_r   [QB];
  logic [XW-1:0]    rem_nxt [QB];
  logic [DW-1:0]    dv_r    [QB];
  logic [DW-1:0]    dv_nxt  [QB];
  logic [QB-1:0]    quo_r   [QB+1];
  logic [QB-1:0]    quo_nxt [QB+1];
  logic [QB:0]      neg_r;
  logic [QB:0]      neg_nxt;
  logic [XW-1:0]    dsh     [QB];
  logic [QB-1:0]    fit;
  logic signed [QB:0] q_nxt;
  logic signed [QB:0] q_r;

  always_comb begin
    rem_nxt[0] = num_i[NW-1] ? XW'(-(NW+1)'(num_i)) : XW'(num_i);
    dv_nxt[0]  = den_i[DW-1] ? DW'(-(DW+1)'(den_i)) : DW'(den_i);
    quo_nxt[0] = '0;
    neg_nxt[0] = num_i[NW-1] ^ den_i[DW-1];
    for (int k = 0; k < QB; k++) begin
      dsh[k]         = XW'(dv_r[k]) << (QB - 1 - k);
      fit[k]         = rem_r[k] >= dsh[k];
      quo_nxt[k+1]   = quo_r[k] | (fit[k] ? (QB'(1) << (QB - 1 - k)) : QB'(0));
      neg_nxt[k+1]   = neg_r[k];
      if (k + 1 < QB) begin
        rem_nxt[k+1] = fit[k] ? rem_r[k] - dsh[k] : rem_r[k];
        dv_nxt[k+1]  = dv_r[k];
      end
    end
    q_nxt = neg_r[QB] ? -$signed((QB+1)'(quo_r[QB])) : $signed((QB+1)'(quo_r[QB]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dv_r  <= dv_nxt;
      quo_r <= quo_nxt;
      neg_r <= neg_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quo_o = q_r;

endmodule

// File: rtl/closest_point_on_triangle_top.sv
// Closest point on triangle: a pipeline from accept to out_valid; one word accepted per
// cycle when the output side keeps up.
// Pipeline depth is dominated by the divider, which resolves one quotient bit per stage.
// The whole pipe advances together; a held output stalls every stage.
// Reset (rst_n low, synchronous) empties the pipe; datapath registers are not reset.
// Depends on cpt_pkg, cpt_mul, cpt_div.
module closest_point_on_triangle_top #(
  parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic signed [COORD_WIDTH-1:0] in_vert_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_vert_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_vert_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_c_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_near_x,
  output logic signed [COORD_WIDTH-1:0] out_near_y,
  output logic signed [COORD_WIDTH-1:0] out_near_z,
  output logic [2:0]                    out_region,
  output logic                          out_degenerate
);
  import cpt_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int D1W  = W + 1;        // coordinate differences
  localparam int PW1  = 2 * W + 2;    // one product of differences
  localparam int DOTW = 2 * W + 4;    // dot products
  localparam int CRW  = 2 * W + 3;    // cross product components
  localparam int PTW  = 2 * CRW;      // one triple-product term
  localparam int TRW  = 4 * W + 8;    // triple products va, vb, vc
  localparam int SUMW = 4 * W + 10;   // divisor
  localparam int MPW  = D1W + TRW;    // numerator terms
  localparam int NUMW = 5 * W + 11;   // numerator
  localparam int QB   = W + 1;        // quotient magnitude bits
  localparam int DLAT = QB + 2;       // divider latency
  localparam int LAT  = 10 + DLAT;    // total latency

  typedef logic signed [W-1:0]   crd_t;
  typedef logic signed [D1W-1:0] d1_t;
  typedef logic signed [PW1-1:0] p1_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [CRW-1:0] cr_t;
  typedef logic signed [PTW-1:0] pt_t;
  typedef logic signed [TRW-1:0] tr_t;
  typedef logic signed [SUMW-1:0] sum_t;
  typedef logic signed [MPW-1:0] mp_t;
  typedef logic signed [NUMW-1:0] num_t;

  typedef struct packed {
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] base;
    region_t           rg;
    logic              useq;   // add the quotient to base
    logic              deg;
  } side_t;

  // ---------------------------------------------------------------- flow control
  logic [LAT-1:0] vld_r;
  logic           adv;

  assign adv       = ~vld_r[LAT-1] | out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------- stage 1: differences
  crd_t pin [3];
  crd_t ain [3];
  crd_t bin [3];
  crd_t cin [3];

  assign pin = '{in_point_x, in_point_y, in_point_z};
  assign ain = '{in_vert_a_x, in_vert_a_y, in_vert_a_z};
  assign bin = '{in_vert_b_x, in_vert_b_y, in_vert_b_z};
  assign cin = '{in_vert_c_x, in_vert_c_y, in_vert_c_z};

  // vertices and edges ride along to stage 6
  crd_t a_r  [6][3];
  crd_t b_r  [6][3];
  crd_t c_r  [6][3];
  d1_t  ab_r [6][3];
  d1_t  ac_r [6][3];
  d1_t  bc_r [6][3];
  d1_t  pa_r [3];
  d1_t  pb_r [3];
  d1_t  pc_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_r[0][i]  <= ain[i];
        b_r[0][i]  <= bin[i];
        c_r[0][i]  <= cin[i];
        ab_r[0][i] <= D1W'(bin[i]) - D1W'(ain[i]);
        ac_r[0][i] <= D1W'(cin[i]) - D1W'(ain[i]);
        bc_r[0][i] <= D1W'(cin[i]) - D1W'(bin[i]);
        pa_r[i]    <= D1W'(pin[i]) - D1W'(ain[i]);
        pb_r[i]    <= D1W'(pin[i]) - D1W'(bin[i]);
        pc_r[i]    <= D1W'(pin[i]) - D1W'(cin[i]);
      end
      for (int s = 1; s < 6; s++) begin
        a_r[s]  <= a_r[s-1];
        b_r[s]  <= b_r[s-1];
        c_r[s]  <= c_r[s-1];
        ab_r[s] <= ab_r[s-1];
        ac_r[s] <= ac_r[s-1];
        bc_r[s] <= bc_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  // dots: 0 pa.ab (snom), 1 pb.ab (-sden), 2 pa.ac (tnom), 3 pc.ac (-tden),
  //       4 pb.bc (unom), 5 pc.bc (-uden)
  // crosses: 0 ab x ac (normal), 1 pa x pb, 2 pb x pc, 3 pc x pa
  d1_t dl [6][3];
  d1_t dr [6][3];
  d1_t cx [4][3];
  d1_t cy [4][3];
  p1_t dp_nxt [6][3];
  p1_t dp_r   [6][3];
  p1_t cp_nxt [4][3][2];
  p1_t cp_r   [4][3][2];

  always_comb begin
    int j;
    int m;
    dl[0] = pa_r;    dr[0] = ab_r[0];
    dl[1] = pb_r;    dr[1] = ab_r[0];
    dl[2] = pa_r;    dr[2] = ac_r[0];
    dl[3] = pc_r;    dr[3] = ac_r[0];
    dl[4] = pb_r;    dr[4] = bc_r[0];
    dl[5] = pc_r;    dr[5] = bc_r[0];
    cx[0] = ab_r[0]; cy[0] = ac_r[0];
    cx[1] = pa_r;    cy[1] = pb_r;
    cx[2] = pb_r;    cy[2] = pc_r;
    cx[3] = pc_r;    cy[3] = pa_r;
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < 3; i++) begin
        dp_nxt[k][i] = PW1'(dl[k][i]) * PW1'(dr[k][i]);
      end
    end
    for (int t = 0; t < 4; t++) begin
      for (int i = 0; i < 3; i++) begin
        j = (i == 2) ? 0 : i + 1;
        m = (i == 0) ? 2 : i - 1;
        cp_nxt[t][i][0] = PW1'(cx[t][j]) * PW1'(cy[t][m]);
        cp_nxt[t][i][1] = PW1'(cx[t][m]) * PW1'(cy[t][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dp_r <= dp_nxt;
      cp_r <= cp_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3: sums
  dot_t dots_nxt [6];
  dot_t dots3_r  [6];
  dot_t dots4_r  [6];
  dot_t dots5_r  [6];
  dot_t dots6_r  [6];
  cr_t  crs_nxt  [4][3];
  cr_t  crs3_r   [4][3];

  always_comb begin
    dot_t s;
    for (int k = 0; k < 6; k++) begin
      s = DOTW'(dp_r[k][0]) + DOTW'(dp_r[k][1]) + DOTW'(dp_r[k][2]);
      // odd entries are the denominators, taken against the reversed edge
      dots_nxt[k] = (k % 2 == 1) ? -s : s;
    end
    for (int t = 0; t < 4; t++) begin
      for (int i = 0; i < 3; i++) begin
        crs_nxt[t][i] = CRW'(cp_r[t][i][0]) - CRW'(cp_r[t][i][1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dots3_r <= dots_nxt;
      crs3_r  <= crs_nxt;
      dots4_r <= dots3_r;
      dots5_r <= dots4_r;
      dots6_r <= dots5_r;
    end
  end

  // ---------------------------------------------------------------- stages 4-5: n . cross terms
  pt_t tp [3][3];

  for (genvar t = 0; t < 3; t++) begin : g_tri
    for (genvar i = 0; i < 3; i++) begin : g_comp
      cpt_mul #(
        .AW (CRW),
        .BW (CRW)
      ) u_mul (
        .clk (clk),
        .en  (adv),
        .a_i (crs3_r[0][i]),
        .b_i (crs3_r[t+1][i]),
        .p_o (tp[t][i])
      );
    end
  end

  // ---------------------------------------------------------------- stage 6: vc, va, vb
  tr_t tri_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 3; t++) begin
        tri_r[t] <= TRW'(tp[t][0]) + TRW'(tp[t][1]) + TRW'(tp[t][2]);
      end
    end
  end

  // ---------------------------------------------------------------- region decision
  dot_t  snom, sden, tnom, tden, unom, uden;
  tr_t   vc, va, vb;
  side_t side6;
  sum_t  den6;
  logic  face6;
  d1_t   m0a [3];
  tr_t   m0b;
  d1_t   m1a [3];
  d1_t   m2a [3];

  assign snom = dots6_r[0];
  assign sden = dots6_r[1];
  assign tnom = dots6_r[2];
  assign tden = dots6_r[3];
  assign unom = dots6_r[4];
  assign uden = dots6_r[5];
  assign vc   = tri_r[0];
  assign va   = tri_r[1];
  assign vb   = tri_r[2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side6.a[i]    = a_r[5][i];
      side6.base[i] = '0;
      m0a[i]        = D1W'(a_r[5][i]);
      m1a[i]        = D1W'(b_r[5][i]);
      m2a[i]        = D1W'(c_r[5][i]);
    end
    side6.rg   = RGN_FACE;
    side6.useq = 1'b1;
    side6.deg  = 1'b0;
    m0b        = va;
    den6       = SUMW'(va) + SUMW'(vb) + SUMW'(vc);
    face6      = 1'b1;
    if (snom <= 0 && tnom <= 0) begin
      side6.rg   = RGN_A;
      side6.useq = 1'b0;
      face6      = 1'b0;
      for (int i = 0; i < 3; i++) side6.base[i] = a_r[5][i];
    end else if (sden <= 0 && unom <= 0) begin
      side6.rg   = RGN_B;
      side6.useq = 1'b0;
      face6      = 1'b0;
      for (int i = 0; i < 3; i++) side6.base[i] = b_r[5][i];
    end else if (tden <= 0 && uden <= 0) begin
      side6.rg   = RGN_C;
      side6.useq = 1'b0;
      face6      = 1'b0;
      for (int i = 0; i < 3; i++) side6.base[i] = c_r[5][i];
    end else if (vc <= 0 && snom >= 0 && sden >= 0) begin
      side6.rg = RGN_AB;
      face6    = 1'b0;
      m0b      = TRW'(snom);
      den6     = SUMW'(snom) + SUMW'(sden);
      for (int i = 0; i < 3; i++) begin
        side6.base[i] = a_r[5][i];
        m0a[i]        = ab_r[5][i];
      end
    end else if (va <= 0 && unom >= 0 && uden >= 0) begin
      side6.rg = RGN_BC;
      face6    = 1'b0;
      m0b      = TRW'(unom);
      den6     = SUMW'(unom) + SUMW'(uden);
      for (int i = 0; i < 3; i++) begin
        side6.base[i] = b_r[5][i];
        m0a[i]        = bc_r[5][i];
      end
    end else if (vb <= 0 && tnom >= 0 && tden >= 0) begin
      side6.rg = RGN_CA;
      face6    = 1'b0;
      m0b      = TRW'(tnom);
      den6     = SUMW'(tnom) + SUMW'(tden);
      for (int i = 0; i < 3; i++) begin
        side6.base[i] = a_r[5][i];
        m0a[i]        = ac_r[5][i];
      end
    end
  end

  // ---------------------------------------------------------------- stages 7-8: numerator terms
  // edge: term 0 is dir * nom; face: the three weighted vertices
  mp_t mp [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_num
    cpt_mul #(.AW(D1W), .BW(TRW)) u_mul0 (
      .clk (clk), .en (adv), .a_i (m0a[i]), .b_i (m0b), .p_o (mp[0][i])
    );
    cpt_mul #(.AW(D1W), .BW(TRW)) u_mul1 (
      .clk (clk), .en (adv), .a_i (m1a[i]), .b_i (vb), .p_o (mp[1][i])
    );
    cpt_mul #(.AW(D1W), .BW(TRW)) u_mul2 (
      .clk (clk), .en (adv), .a_i (m2a[i]), .b_i (vc), .p_o (mp[2][i])
    );
  end

  side_t side7_r, side8_r, side9_r;
  sum_t  den7_r, den8_r, den9_r;
  logic  face7_r, face8_r;
  num_t  num9_r [3];
  side_t side9_nxt;

  // zero divisor on an edge or the face falls back to vertex A
  always_comb begin
    side9_nxt = side8_r;
    if (side8_r.useq && den8_r == '0) begin
      side9_nxt.base = side8_r.a;
      side9_nxt.rg   = RGN_A;
      side9_nxt.useq = 1'b0;
      side9_nxt.deg  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side7_r <= side6;
      den7_r  <= den6;
      face7_r <= face6;
      side8_r <= side7_r;
      den8_r  <= den7_r;
      face8_r <= face7_r;
      side9_r <= side9_nxt;
      den9_r  <= den8_r;
      for (int i = 0; i < 3; i++) begin
        num9_r[i] <= face8_r ? NUMW'(mp[0][i]) + NUMW'(mp[1][i]) + NUMW'(mp[2][i])
                             : NUMW'(mp[0][i]);
      end
    end
  end

  // ---------------------------------------------------------------- dividers
  logic signed [QB:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    cpt_div #(
      .NW (NUMW),
      .DW (SUMW),
      .QB (QB)
    ) u_div (
      .clk   (clk),
      .en    (adv),
      .num_i (num9_r[i]),
      .den_i (den9_r),
      .quo_o (quo[i])
    );
  end

  side_t sd_r [DLAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= side9_r;
      for (int k = 1; k < DLAT; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  // ---------------------------------------------------------------- output word
  crd_t    near_r [3];
  region_t rg_r;
  logic    deg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        near_r[i] <= sd_r[DLAT-1].base[i] + (sd_r[DLAT-1].useq ? W'(quo[i]) : W'(0));
      end
      rg_r  <= sd_r[DLAT-1].rg;
      deg_r <= sd_r[DLAT-1].deg;
    end
  end

  assign out_near_x     = near_r[0];
  assign out_near_y     = near_r[1];
  assign out_near_z     = near_r[2];
  assign out_region     = rg_r;
  assign out_degenerate = deg_r;

endmodule
